// File: hw/rtl/zas_pkg.sv
// Shared types and constants for the zone alarm scheduler.
`default_nettype none

package zas_pkg;

    // Event codes; codes above OP_TRIP are ignored
    typedef enum logic [3:0] {
        OP_TICK      = 4'd0,
        OP_ARM       = 4'd1,
        OP_DISARM    = 4'd2,
        OP_SET_WIN   = 4'd3,
        OP_CLR_WIN   = 4'd4,
        OP_CLOCK_SET = 4'd5,
        OP_TOGGLE    = 4'd6,
        OP_HUSH      = 4'd7,
        OP_TRIP      = 4'd8
    } t_op;

    localparam logic [1:0] ZONE_OFF   = 2'd0;
    localparam logic [1:0] ZONE_ARMED = 2'd1;
    localparam logic [1:0] ZONE_ALARM = 2'd2;

    localparam int MAX_ZONES = 4;

    // Seconds per day and its reciprocal for the modulo reduction.
    // 86400 = 128 * 675; quotient = ((x >> 7) * RECIP) >> RECIP_SHIFT,
    // which is exact or one short.
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [25:0] RECIP        = 26'd50903316;
    localparam int          RECIP_SHIFT  = 35;

    // One event as it travels down the pipeline
    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  room;
        logic [16:0] win_start;
        logic [16:0] win_end;
    } t_event;

    // Status after an event
    typedef struct packed {
        logic [3:0] latches;
        logic [3:0] enables;
        logic [7:0] states;
    } t_status;

endpackage

`default_nettype wire

// File: hw/rtl/zone_alarm_scheduler.sv
// Top level of the zone alarm scheduler: request pipeline and output register.
`default_nettype none

// Four-zone alarm controller. Each request on the slave stream is one event
// (tick, arm, disarm, set/clear window, clock set, toggle all, hush, trip);
// each produces exactly one status word on the master stream, in order.
// A new request is taken every cycle while the output is not stalled, so the
// sustained rate is one request per clock. The pipeline is the input
// register, two stages that reduce the tick seconds modulo 86400 by a
// reciprocal multiply, then the combinational zone update that loads the
// output register. Backpressure stalls the whole pipeline together; a full
// output register that is being taken does not stall it. Codes 9 to 15 and
// room numbers at or above NUM_ZONES change nothing but still report status.
// Zones at or above NUM_ZONES read as zero in every status field.

module zone_alarm_scheduler #(
    parameter int NUM_ZONES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request: op[3:0], room[5:4], clock_seconds[37:6],
    //          window_start[54:38], window_end[71:55]
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,
    // status: zone_states[7:0], schedule_enables[11:8], window_latches[15:12]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata
);
    import zas_pkg::*;

    logic    en;
    logic    r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    t_event  r_s1_evt, r_s2_evt, r_s3_evt;
    logic [31:0] r_s1_secs;
    logic [16:0] time_of_day;
    t_status next_status;
    t_status r_out_status;
    t_event  in_evt;

    // whole pipeline moves unless the result register is held
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    assign in_evt.op        = s_axis_tdata[3:0];
    assign in_evt.room      = s_axis_tdata[5:4];
    assign in_evt.win_start = s_axis_tdata[54:38];
    assign in_evt.win_end   = s_axis_tdata[71:55];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= s_axis_tvalid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_evt     <= in_evt;
            r_s1_secs    <= s_axis_tdata[37:6];
            r_s2_evt     <= r_s1_evt;
            r_s3_evt     <= r_s2_evt;
            r_out_status <= next_status;
        end
    end

    zas_day_mod u_day_mod (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_seconds     (r_s1_secs),
        .o_time_of_day (time_of_day)
    );

    // state commits only for a real request leaving stage 3
    zas_zone_bank #(
        .NUM_ZONES (NUM_ZONES)
    ) u_zone_bank (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (en && r_s3_valid),
        .i_event       (r_s3_evt),
        .i_time_of_day (time_of_day),
        .o_next_status (next_status)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_status;

endmodule

`default_nettype wire

// File: hw/rtl/zas_day_mod.sv
// Two-stage reduction of a 32-bit seconds count modulo one day.
`default_nettype none

module zas_day_mod (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_seconds,
    output logic [16:0]      o_time_of_day
);
    import zas_pkg::*;

    logic [50:0] r_prod;
    logic [31:0] r_x;
    logic [17:0] r_rem;
    logic [15:0] quot;
    logic [31:0] diff;
    logic [50:0] n_prod;

    assign n_prod = {26'd0, i_seconds[31:7]} * {25'd0, RECIP};
    assign quot   = r_prod[50:RECIP_SHIFT];
    assign diff   = r_x - ({16'd0, quot} * {15'd0, SECS_PER_DAY});

    // stage 1: reciprocal product; stage 2: remainder, below two days
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_x    <= i_seconds;
            r_rem  <= diff[17:0];
        end
    end

    // final correction, quotient estimate may be one short
    always_comb begin
        if (r_rem >= {1'b0, SECS_PER_DAY}) begin
            o_time_of_day = 17'(r_rem - {1'b0, SECS_PER_DAY});
        end else begin
            o_time_of_day = r_rem[16:0];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/zas_zone_bank.sv
// Zone state, schedule windows and latches, updated once per event.
`default_nettype none

module zas_zone_bank #(
    parameter int NUM_ZONES = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire zas_pkg::t_event i_event,
    input  wire logic [16:0]     i_time_of_day,
    output zas_pkg::t_status     o_next_status
);
    import zas_pkg::*;

    logic [1:0]  r_zone_state  [NUM_ZONES];
    logic        r_sched_en    [NUM_ZONES];
    logic        r_latch       [NUM_ZONES];
    logic [16:0] r_arm_time    [NUM_ZONES];
    logic [16:0] r_disarm_time [NUM_ZONES];

    logic [1:0]  n_zone_state  [NUM_ZONES];
    logic        n_sched_en    [NUM_ZONES];
    logic        n_latch       [NUM_ZONES];
    logic [16:0] n_arm_time    [NUM_ZONES];
    logic [16:0] n_disarm_time [NUM_ZONES];

    logic any_on;

    always_comb begin
        any_on = 1'b0;
        for (int z = 0; z < NUM_ZONES; z++) begin
            if (r_zone_state[z] != ZONE_OFF) begin
                any_on = 1'b1;
            end
        end
    end

    always_comb begin
        logic hit, in_win, release_win, wraps;
        logic [16:0] t;
        t = i_time_of_day;
        for (int z = 0; z < NUM_ZONES; z++) begin
            n_zone_state[z]  = r_zone_state[z];
            n_sched_en[z]    = r_sched_en[z];
            n_latch[z]       = r_latch[z];
            n_arm_time[z]    = r_arm_time[z];
            n_disarm_time[z] = r_disarm_time[z];
            hit   = (i_event.room == 2'(z));
            wraps = r_arm_time[z] > r_disarm_time[z];
            if (wraps) begin
                in_win      = (t >= r_arm_time[z]) || (t <= r_disarm_time[z]);
                release_win = (t > r_disarm_time[z]) && (t < r_arm_time[z]);
            end else begin
                in_win      = (t >= r_arm_time[z]) && (t <= r_disarm_time[z]);
                release_win = (t > r_disarm_time[z]);
            end
            unique case (i_event.op)
                OP_TICK: begin
                    if (r_sched_en[z]) begin
                        if (in_win && !r_latch[z]) begin
                            if (r_zone_state[z] != ZONE_ALARM) begin
                                n_latch[z]      = 1'b1;
                                n_zone_state[z] = ZONE_ARMED;
                            end
                        end else if (release_win && r_latch[z]) begin
                            n_latch[z] = 1'b0;
                            if (r_zone_state[z] != ZONE_ALARM) begin
                                n_zone_state[z] = ZONE_OFF;
                            end
                        end
                    end
                end
                OP_ARM: begin
                    if (hit) n_zone_state[z] = ZONE_ARMED;
                end
                OP_DISARM: begin
                    if (hit) n_zone_state[z] = ZONE_OFF;
                end
                OP_SET_WIN: begin
                    if (hit) begin
                        n_arm_time[z]    = i_event.win_start;
                        n_disarm_time[z] = i_event.win_end;
                        n_sched_en[z]    = 1'b1;
                    end
                end
                OP_CLR_WIN: begin
                    if (hit) n_sched_en[z] = 1'b0;
                end
                OP_CLOCK_SET: begin
                    n_latch[z] = 1'b0;
                end
                OP_TOGGLE: begin
                    n_zone_state[z] = any_on ? ZONE_OFF : ZONE_ARMED;
                end
                OP_HUSH: begin
                    if (r_zone_state[z] == ZONE_ALARM) n_zone_state[z] = ZONE_ARMED;
                end
                OP_TRIP: begin
                    if (hit && r_zone_state[z] == ZONE_ARMED) begin
                        n_zone_state[z] = ZONE_ALARM;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // zones beyond NUM_ZONES report zero
    always_comb begin
        o_next_status = '0;
        for (int z = 0; z < NUM_ZONES; z++) begin
            o_next_status.states[2*z +: 2] = n_zone_state[z];
            o_next_status.enables[z]       = n_sched_en[z];
            o_next_status.latches[z]       = n_latch[z];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int z = 0; z < NUM_ZONES; z++) begin
                r_zone_state[z]  <= ZONE_OFF;
                r_sched_en[z]    <= 1'b0;
                r_latch[z]       <= 1'b0;
                r_arm_time[z]    <= '0;
                r_disarm_time[z] <= '0;
            end
        end else if (i_fire) begin
            for (int z = 0; z < NUM_ZONES; z++) begin
                r_zone_state[z]  <= n_zone_state[z];
                r_sched_en[z]    <= n_sched_en[z];
                r_latch[z]       <= n_latch[z];
                r_arm_time[z]    <= n_arm_time[z];
                r_disarm_time[z] <= n_disarm_time[z];
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/tb_zone_alarm_scheduler.sv
// Self-checking testbench for the zone alarm scheduler stream interface.
`timescale 1ns / 1ps

module tb_zone_alarm_scheduler;

    import zas_pkg::*;

    localparam int ZONES       = MAX_ZONES;
    localparam int DAY_SECS    = int'(SECS_PER_DAY);
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 140;
    localparam int DRAIN_LIMIT = 5000;

    // Codes past the last event change nothing but still report status
    localparam logic [3:0] OP_UNUSED_LO = OP_TRIP + 4'd1;
    localparam logic [3:0] OP_UNUSED_HI = 4'hF;

    // Status predictor and queue of status words still to come
    class zone_status_board;
        logic [1:0]  zone_mode [ZONES];
        logic        win_on    [ZONES];
        logic        win_latch [ZONES];
        logic [16:0] arm_at    [ZONES];
        logic [16:0] disarm_at [ZONES];
        t_status     status_q  [$];
        int unsigned errors;
        int unsigned checked;

        function new();
            for (int z = 0; z < ZONES; z++) begin
                zone_mode[z] = ZONE_OFF;
                win_on[z]    = 1'b0;
                win_latch[z] = 1'b0;
                arm_at[z]    = '0;
                disarm_at[z] = '0;
            end
            errors  = 0;
            checked = 0;
        endfunction

        // Apply one accepted request and queue the status it should produce
        function void note_request(logic [3:0] op, logic [1:0] room, logic [31:0] secs,
                                   logic [16:0] ws, logic [16:0] we);
            logic [31:0] tod;
            logic [31:0] on_t;
            logic [31:0] off_t;
            logic        inside_win;
            logic        release_win;
            logic        room_ok;
            logic [1:0]  next_mode;
            t_status     s;

            room_ok = (int'(room) < ZONES);
            case (op)
                OP_TICK: begin
                    tod = secs % 32'(SECS_PER_DAY);
                    for (int z = 0; z < ZONES; z++) begin
                        if (win_on[z]) begin
                            on_t  = 32'(arm_at[z]);
                            off_t = 32'(disarm_at[z]);
                            if (on_t > off_t) begin
                                // window wraps past midnight
                                inside_win  = (tod >= on_t) || (tod <= off_t);
                                release_win = (tod > off_t) && (tod < on_t);
                            end else begin
                                inside_win  = (tod >= on_t) && (tod <= off_t);
                                release_win = (tod > off_t);
                            end
                            if (inside_win && !win_latch[z]) begin
                                if (zone_mode[z] != ZONE_ALARM) begin
                                    win_latch[z] = 1'b1;
                                    zone_mode[z] = ZONE_ARMED;
                                end
                            end else if (release_win && win_latch[z]) begin
                                win_latch[z] = 1'b0;
                                if (zone_mode[z] != ZONE_ALARM)
                                    zone_mode[z] = ZONE_OFF;
                            end
                        end
                    end
                end
                OP_ARM: begin
                    if (room_ok) zone_mode[room] = ZONE_ARMED;
                end
                OP_DISARM: begin
                    if (room_ok) zone_mode[room] = ZONE_OFF;
                end
                OP_SET_WIN: begin
                    if (room_ok) begin
                        arm_at[room]    = ws;
                        disarm_at[room] = we;
                        win_on[room]    = 1'b1;
                    end
                end
                OP_CLR_WIN: begin
                    if (room_ok) win_on[room] = 1'b0;
                end
                OP_CLOCK_SET: begin
                    for (int z = 0; z < ZONES; z++) win_latch[z] = 1'b0;
                end
                OP_TOGGLE: begin
                    next_mode = ZONE_ARMED;
                    for (int z = 0; z < ZONES; z++)
                        if (zone_mode[z] != ZONE_OFF) next_mode = ZONE_OFF;
                    for (int z = 0; z < ZONES; z++) zone_mode[z] = next_mode;
                end
                OP_HUSH: begin
                    for (int z = 0; z < ZONES; z++)
                        if (zone_mode[z] == ZONE_ALARM) zone_mode[z] = ZONE_ARMED;
                end
                OP_TRIP: begin
                    if (room_ok && zone_mode[room] == ZONE_ARMED) zone_mode[room] = ZONE_ALARM;
                end
                default: ;
            endcase

            s = '0;
            for (int z = 0; z < ZONES; z++) begin
                s.states[2*z +: 2] = zone_mode[z];
                s.enables[z]       = win_on[z];
                s.latches[z]       = win_latch[z];
            end
            status_q.push_back(s);
        endfunction

        // Compare one status word from the block with the oldest prediction
        function void check_status(logic [15:0] act);
            t_status got;
            t_status exp_s;

            got = act;
            if (status_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: status %h arrived with no request outstanding", $time, act);
                return;
            end
            exp_s = status_q.pop_front();
            checked++;
            if (got.states !== exp_s.states || got.enables !== exp_s.enables ||
                got.latches !== exp_s.latches) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: status %0d wrong: states %h/%h enables %h/%h latches %h/%h",
                             $time, checked, exp_s.states, got.states, exp_s.enables,
                             got.enables, exp_s.latches, got.latches);
            end
        endfunction

        function void drop_leftovers();
            if (status_q.size() != 0) begin
                $display("%0d status words never arrived", status_q.size());
                errors += status_q.size();
                status_q.delete();
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    zone_status_board sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned op_count [16];

    zone_alarm_scheduler #(
        .NUM_ZONES(ZONES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random back-pressure, one decision per cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_status(m_axis_tdata);
    end

    // Offer one request, with random gaps before it, and hold until taken
    task automatic send_event(logic [3:0] op, logic [1:0] room, logic [31:0] secs,
                              logic [16:0] ws, logic [16:0] we);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {we, ws, secs, room, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(op, room, secs, ws, we);
        op_count[op]++;
    endtask

    // Random request, weighted towards windows and ticks near their edges
    task automatic send_random_event();
        int unsigned pick;
        int          z;
        int          tod;
        logic [3:0]  op;
        logic [1:0]  room;
        logic [31:0] secs;
        logic [16:0] ws;
        logic [16:0] we;

        pick = $urandom_range(0, 99);
        room = 2'($urandom);
        secs = $urandom;
        ws   = 17'($urandom);
        we   = 17'($urandom);
        if (pick < 30) begin
            op = OP_TICK;
            z  = $urandom_range(0, ZONES - 1);
            case ($urandom_range(0, 6))
                0:       tod = int'(sb.arm_at[z]) - 1;
                1:       tod = int'(sb.arm_at[z]);
                2:       tod = int'(sb.arm_at[z]) + 1;
                3:       tod = int'(sb.disarm_at[z]) - 1;
                4:       tod = int'(sb.disarm_at[z]);
                5:       tod = int'(sb.disarm_at[z]) + 1;
                default: tod = $urandom_range(0, DAY_SECS - 1);
            endcase
            if (tod < 0) tod += DAY_SECS;
            tod  = tod % DAY_SECS;
            // push into a random day so the upper bits of the count move too
            secs = 32'(tod) + 32'(DAY_SECS) * 32'($urandom_range(0, 49709));
        end else if (pick < 45) begin
            op = OP_SET_WIN;
            if ($urandom_range(0, 9) != 0) begin
                ws = 17'($urandom_range(0, DAY_SECS - 1));
                we = 17'($urandom_range(0, DAY_SECS - 1));
            end
        end else if (pick < 53) op = OP_CLR_WIN;
        else if (pick < 63) op = OP_ARM;
        else if (pick < 69) op = OP_DISARM;
        else if (pick < 79) op = OP_TRIP;
        else if (pick < 84) op = OP_HUSH;
        else if (pick < 88) op = OP_TOGGLE;
        else if (pick < 92) op = OP_CLOCK_SET;
        else if (pick < 96) op = OP_TICK;
        else op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        send_event(op, room, secs, ws, we);
    endtask

    initial begin
        int unsigned drain_cycles;

        send_idle_pct = 10;
        recv_idle_pct = 63;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every event, trip/hush/toggle corners, both kinds of window
        send_event(OP_TICK,      2'd0, 32'd0,          17'd0,      17'd0);
        send_event(OP_ARM,       2'd0, 32'd0,          17'd0,      17'd0);
        send_event(OP_TRIP,      2'd0, 32'd0,          17'd0,      17'd0);
        send_event(OP_TRIP,      2'd1, 32'd0,          17'd0,      17'd0);
        send_event(OP_ARM,       2'd3, 32'd0,          17'd0,      17'd0);
        send_event(OP_HUSH,      2'd0, 32'd0,          17'd0,      17'd0);
        send_event(OP_TOGGLE,    2'd0, 32'd0,          17'd0,      17'd0);
        send_event(OP_TOGGLE,    2'd0, 32'd0,          17'd0,      17'd0);
        send_event(OP_SET_WIN,   2'd1, 32'd0,          17'd3600,   17'd7200);
        send_event(OP_TICK,      2'd0, 32'd3600,       17'd0,      17'd0);
        send_event(OP_TRIP,      2'd1, 32'd0,          17'd0,      17'd0);
        // alarming zone leaves its window: latch drops, alarm holds
        send_event(OP_TICK,      2'd0, 32'd7201,       17'd0,      17'd0);
        // window across midnight
        send_event(OP_SET_WIN,   2'd2, 32'd0,          17'd82800,  17'd3600);
        send_event(OP_DISARM,    2'd2, 32'd0,          17'd0,      17'd0);
        send_event(OP_TICK,      2'd0, 32'd259300,     17'd0,      17'd0);
        send_event(OP_CLOCK_SET, 2'd0, 32'd0,          17'd0,      17'd0);
        send_event(OP_TICK,      2'd0, 32'hFFFF_FFFF,  17'd0,      17'd0);
        // window times beyond one day are kept and compared as given
        send_event(OP_SET_WIN,   2'd3, 32'd0,          17'h1FFFF,  17'h1FFFF);
        send_event(OP_TICK,      2'd0, 32'd86399,      17'd0,      17'd0);
        send_event(OP_SET_WIN,   2'd0, 32'hFFFF_FFFF,  17'd0,      17'd0);
        send_event(OP_TICK,      2'd0, 32'd86400,      17'd0,      17'd0);
        send_event(OP_CLR_WIN,   2'd1, 32'd0,          17'd0,      17'd0);
        send_event(OP_UNUSED_LO, 2'd0, 32'd0,          17'd0,      17'd0);
        send_event(OP_UNUSED_HI, 2'd3, 32'hFFFF_FFFF,  17'h1FFFF,  17'h1FFFF);
        send_event(OP_TRIP,      2'd3, 32'd0,          17'd0,      17'd0);

        // Random: three back-pressure phases
        for (int i = 0; i < PHASE_ITEMS; i++) send_random_event();
        send_idle_pct = 63;
        recv_idle_pct = 10;
        for (int i = 0; i < PHASE_ITEMS; i++) send_random_event();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < PHASE_ITEMS; i++) send_random_event();
        s_axis_tvalid <= 1'b0;

        drain_cycles = 0;
        while (sb.status_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(posedge i_clk);
        sb.drop_leftovers();

        $display("Sent %0d events: %0d ticks, %0d window writes, %0d trips, %0d unused codes",
                 sb.checked, op_count[OP_TICK], op_count[OP_SET_WIN], op_count[OP_TRIP],
                 op_count[9] + op_count[10] + op_count[11] + op_count[12] +
                 op_count[13] + op_count[14] + op_count[15]);
        $display("Three stall patterns on both streams, %0d failures", sb.errors);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: reports a time-out and ends the run
    initial begin
        #1_000_000;
        $display("Timed out waiting for the block");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: zone_alarm_scheduler.f
hw/rtl/zas_pkg.sv
hw/rtl/zas_day_mod.sv
hw/rtl/zas_zone_bank.sv
hw/rtl/zone_alarm_scheduler.sv
tb/tb_zone_alarm_scheduler.sv
